### rtl/dcc_packet_framer_core_assert.svh
// Assertion macros for the DCC packet framer.
// Each macro takes a label, a clock, a reset, a premise, a consequence and a message.
`ifndef DCC_PACKET_FRAMER_CORE_ASSERT_SVH
`define DCC_PACKET_FRAMER_CORE_ASSERT_SVH

// Consequence holds in the same cycle as the premise.
`define DCC_ASSERT_SAME(label, clk, rst, pre, con, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
    else $error(msg);

// Consequence holds in the cycle after the premise.
`define DCC_ASSERT_NEXT(label, clk, rst, pre, con, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
    else $error(msg);

`endif

### rtl/dcc_pkg.sv
// ---------------------------------------------------------------------------
// dcc_pkg
// Shared constants, codes and the cell record of the DCC packet framer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcc_pkg;

  // Data bytes that the request can carry and the configured limit.
  localparam int MAX_DATA    = 5;
  localparam int DATA_FIELDS = 5;
  localparam int DATA_LIMIT  = (MAX_DATA < DATA_FIELDS) ? MAX_DATA : DATA_FIELDS;

  // Two address bytes, the data bytes and the check byte.
  localparam int ADDR_MAX = 2;
  localparam int CELLS    = ADDR_MAX + DATA_LIMIT + 1;
  localparam int POS_W    = $clog2(CELLS + 1);
  localparam int DIDX_W   = (DATA_FIELDS > 1) ? $clog2(DATA_FIELDS) : 1;

  // Packet kinds.
  localparam logic [2:0] KIND_IDLE  = 3'd0;
  localparam logic [2:0] KIND_MULTI = 3'd1;
  localparam logic [2:0] KIND_BASIC = 3'd2;
  localparam logic [2:0] KIND_OTHER = 3'd3;

  // Fixed byte patterns.
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  // One stage of the output chain.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } cell_t;

endpackage

### rtl/dcc_req_if.sv
// ---------------------------------------------------------------------------
// dcc_req_if
// Packet request channel: kind, address form, address and data bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       long_address;
  logic [13:0] address;
  logic [2:0] data_count;
  logic [7:0] data_0;
  logic [7:0] data_1;
  logic [7:0] data_2;
  logic [7:0] data_3;
  logic [7:0] data_4;

  modport source (
    output valid, kind, long_address, address, data_count,
           data_0, data_1, data_2, data_3, data_4,
    input  ready
  );
  modport sink (
    input  valid, kind, long_address, address, data_count,
           data_0, data_1, data_2, data_3, data_4,
    output ready
  );
endinterface

### rtl/dcc_byte_if.sv
// ---------------------------------------------------------------------------
// dcc_byte_if
// Packet byte channel: one byte per beat, last marks the check byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

### rtl/dcc_cell.sv
// ---------------------------------------------------------------------------
// dcc_cell
// One byte stage of the output chain: loads from the framer or takes the
// byte of its upstream neighbor when the chain advances.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          shift,
  input  dcc_pkg::cell_t load_val,
  input  dcc_pkg::cell_t from_next,
  output dcc_pkg::cell_t cur
);

  logic       vld;
  logic [7:0] data;
  logic       last;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= load_val.vld;
    end else if (shift) begin
      vld <= from_next.vld;
    end
  end

  // Byte and end marker
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_val.data;
      last <= load_val.last;
    end else if (shift) begin
      data <= from_next.data;
      last <= from_next.last;
    end
  end

  assign cur = '{vld: vld, data: data, last: last};

endmodule

### rtl/dcc_frame_load.sv
// ---------------------------------------------------------------------------
// dcc_frame_load
// Lays out one request as packed chain contents: address bytes, data bytes,
// then the XOR check byte, with the unused cells empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcc_frame_load (
  dcc_req_if.sink  req,
  output dcc_pkg::cell_t frame [dcc_pkg::CELLS]
);

  logic [7:0]                   data [dcc_pkg::DATA_FIELDS];
  logic [7:0]                   addr_0;
  logic [7:0]                   addr_1;
  logic [dcc_pkg::POS_W-1:0]    n_addr;
  logic [dcc_pkg::POS_W-1:0]    n_data;
  logic                         supported;
  logic [7:0]                   chk;

  function automatic logic [dcc_pkg::POS_W-1:0] POS_W_EXT(input logic [2:0] v);
    POS_W_EXT = dcc_pkg::POS_W'(v);
  endfunction

  assign data[0] = req.data_0;
  assign data[1] = req.data_1;
  assign data[2] = req.data_2;
  assign data[3] = req.data_3;
  assign data[4] = req.data_4;

  // Address bytes by kind
  always_comb begin
    addr_0    = 8'h00;
    addr_1    = 8'h00;
    n_addr    = '0;
    supported = 1'b1;
    unique case (req.kind)
      dcc_pkg::KIND_IDLE: begin
        addr_0 = dcc_pkg::IDLE_BYTE;
        n_addr = dcc_pkg::POS_W'(1);
      end
      dcc_pkg::KIND_MULTI: begin
        if (req.long_address) begin
          addr_0 = {2'b11, req.address[13:8]};
          addr_1 = req.address[7:0];
          n_addr = dcc_pkg::POS_W'(2);
        end else begin
          addr_0 = {1'b0, req.address[6:0]};
          n_addr = dcc_pkg::POS_W'(1);
        end
      end
      dcc_pkg::KIND_BASIC: begin
        addr_0 = {2'b10, req.address[5:0]};
        addr_1 = {1'b1, ~req.address[8:6], 1'b1, req.data_0[2:0]};
        n_addr = dcc_pkg::POS_W'(2);
      end
      dcc_pkg::KIND_OTHER: begin
        n_addr = '0;
      end
      default: begin
        supported = 1'b0;
      end
    endcase
  end

  // Saturated data count
  assign n_data = (POS_W_EXT(req.data_count) > dcc_pkg::POS_W'(dcc_pkg::DATA_LIMIT))
                ? dcc_pkg::POS_W'(dcc_pkg::DATA_LIMIT) : POS_W_EXT(req.data_count);

  // Check byte over address and data bytes
  always_comb begin
    chk = 8'h00;
    if (n_addr > dcc_pkg::POS_W'(0)) chk = chk ^ addr_0;
    if (n_addr > dcc_pkg::POS_W'(1)) chk = chk ^ addr_1;
    for (int k = 0; k < dcc_pkg::DATA_LIMIT; k++) begin
      if (dcc_pkg::POS_W'(k) < n_data) chk = chk ^ data[k];
    end
  end

  // Place each byte in its cell
  always_comb begin
    logic [dcc_pkg::POS_W-1:0] pos;
    logic [dcc_pkg::POS_W-1:0] didx;
    for (int p = 0; p < dcc_pkg::CELLS; p++) begin
      pos      = dcc_pkg::POS_W'(p);
      didx     = pos - n_addr;
      frame[p] = '{vld: 1'b0, data: 8'h00, last: 1'b0};
      if (supported) begin
        if (pos < n_addr) begin
          frame[p] = '{vld: 1'b1, data: (pos == '0) ? addr_0 : addr_1, last: 1'b0};
        end else if (didx < n_data) begin
          frame[p] = '{vld: 1'b1, data: data[didx[dcc_pkg::DIDX_W-1:0]], last: 1'b0};
        end else if (didx == n_data) begin
          frame[p] = '{vld: 1'b1, data: chk, last: 1'b1};
        end
      end
    end
  end

endmodule

### rtl/dcc_packet_framer_core.sv
// ---------------------------------------------------------------------------
// dcc_packet_framer_core
// Frames a DCC control packet request into its byte stream with an XOR
// check byte; the bytes leave through a row of shifting cells.
// ---------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   kind, long_address, address, data_count, data_0..data_4
//  pkt      out  out_byte, last (set on the check byte)
//
//  A packet of n bytes (address bytes + data bytes + check byte, 1 to 8)
//  occupies the cell chain until its check byte is handed off; one byte
//  leaves per cycle while pkt is ready. The next request is taken in the
//  cycle the final byte is handed off, so packets follow each other with
//  no gap. An unsupported kind takes one beat and yields no bytes. Reset
//  empties the chain; a stall on pkt holds every cell in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dcc_packet_framer_core_assert.svh"

module dcc_packet_framer_core (
  input  logic      clk,
  input  logic      rst,
  dcc_req_if.sink   req,
  dcc_byte_if.source pkt
);

  dcc_pkg::cell_t frame [dcc_pkg::CELLS];
  dcc_pkg::cell_t cells [dcc_pkg::CELLS];
  logic           load;
  logic           shift;

  // Request framing
  dcc_frame_load u_load (
    .req   (req),
    .frame (frame)
  );

  // Chain control: take a request when the chain is empty or only the head byte is left and leaving
  assign shift     = cells[0].vld && pkt.ready;
  assign req.ready = !cells[1].vld && (!cells[0].vld || pkt.ready);
  assign load      = req.valid && req.ready;

  // Cell chain, head at index zero
  for (genvar i = 0; i < dcc_pkg::CELLS; i++) begin : g_cell
    dcc_pkg::cell_t nxt;
    if (i == dcc_pkg::CELLS - 1) begin : g_tail
      assign nxt = '{vld: 1'b0, data: 8'h00, last: 1'b0};
    end else begin : g_mid
      assign nxt = cells[i+1];
    end
    dcc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (load),
      .shift     (shift),
      .load_val  (frame[i]),
      .from_next (nxt),
      .cur       (cells[i])
    );
  end

  // Output from the head cell
  assign pkt.valid    = cells[0].vld;
  assign pkt.out_byte = cells[0].data;
  assign pkt.last     = cells[0].last;

  // Checks
  `DCC_ASSERT_SAME(a_ready_drained, clk, rst, req.ready, !cells[1].vld,
    "request taken while chain still holds bytes")
  `DCC_ASSERT_SAME(a_chain_packed, clk, rst, !cells[0].vld, !cells[1].vld,
    "gap at the head of the cell chain")
  `DCC_ASSERT_SAME(a_last_is_tail, clk, rst, cells[0].vld && cells[0].last,
    !cells[1].vld, "bytes queued behind the check byte")
  `DCC_ASSERT_NEXT(a_load_shows, clk, rst, load && !req.kind[2], pkt.valid,
    "supported request produced no byte")

endmodule

### tb/tb_dcc_packet_framer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dcc_packet_framer_core
// Self-checking bench for the DCC packet framer. Requests of every kind,
// address form and data length go in through bursts with random gaps. An
// independent framing model predicts each packet's bytes and XOR check byte,
// and a scoreboard compares every output beat in order. The byte sink
// stalls on shifting patterns and holds off once for a long stretch to
// back the framer up into its request port.
// ---------------------------------------------------------------------------

module tb_dcc_packet_framer_core;

  localparam logic [2:0]  KIND_UNSUPPORTED = 3'd4;
  localparam logic [2:0]  KIND_TOP         = 3'd7;
  localparam int          RANDOM_PACKETS   = 400;
  localparam int          HOLD_AT          = 150;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          STALL_LIMIT      = 4000;
  localparam int          DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic [2:0]                           kind;
    logic                                 long_address;
    logic [13:0]                          address;
    logic [2:0]                           data_count;
    logic [dcc_pkg::DATA_FIELDS-1:0][7:0] data;
  } dcc_request_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } framed_byte_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_PATTERN, SINK_HEAVY} sink_mode_t;

  // Predicts packet bytes per request and checks the byte stream in order.
  class framer_scoreboard;
    framed_byte_t pending_bytes[$];
    int unsigned  requests_seen;
    int unsigned  silent_requests;
    int unsigned  bytes_checked;
    int unsigned  mismatches;

    function void frame_request(dcc_request_t r);
      logic [7:0]  body[$];
      logic [7:0]  check;
      logic [13:0] inv_addr;
      int unsigned n_data;
      requests_seen++;
      n_data = (r.data_count > dcc_pkg::DATA_LIMIT) ? dcc_pkg::DATA_LIMIT : r.data_count;
      case (r.kind)
        dcc_pkg::KIND_IDLE: begin
          body.push_back(dcc_pkg::IDLE_BYTE);
        end
        dcc_pkg::KIND_MULTI: begin
          if (r.long_address) begin
            body.push_back(8'hC0 | {2'b00, r.address[13:8]});
            body.push_back(r.address[7:0]);
          end else begin
            body.push_back({1'b0, r.address[6:0]});
          end
        end
        dcc_pkg::KIND_BASIC: begin
          // second byte carries the inverted upper address bits and data_0[2:0]
          inv_addr = ~(r.address >> 2);
          body.push_back(8'h80 | {2'b00, r.address[5:0]});
          body.push_back(8'h88 | (inv_addr[7:0] & 8'h70) | {5'b0, r.data[0][2:0]});
        end
        dcc_pkg::KIND_OTHER: begin
        end
        default: begin
          silent_requests++;
          return;
        end
      endcase
      for (int k = 0; k < n_data; k++) body.push_back(r.data[k]);
      check = 8'h00;
      foreach (body[i]) begin
        check ^= body[i];
        pending_bytes.push_back('{value: body[i], last: 1'b0});
      end
      pending_bytes.push_back('{value: check, last: 1'b1});
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      framed_byte_t want;
      if (pending_bytes.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected beat byte=%02h last=%0b", $time, value, last);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (want.value !== value || want.last !== last) begin
        if (mismatches < 10)
          $display("%0t: beat %0d expected byte=%02h last=%0b, got byte=%02h last=%0b",
                   $time, bytes_checked, want.value, want.last, value, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dcc_req_if  req_ch();
  dcc_byte_if pkt_ch();

  dcc_packet_framer_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pkt (pkt_ch)
  );

  framer_scoreboard sb = new();
  int unsigned      requests_sent;
  int unsigned      stall_run;
  int unsigned      burst_left;
  dcc_request_t     seen_req;
  logic             beat_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor both channels at the rising edge; track cycles with no beat
  always @(posedge clk) begin
    beat_seen = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen_req.kind         = req_ch.kind;
        seen_req.long_address = req_ch.long_address;
        seen_req.address      = req_ch.address;
        seen_req.data_count   = req_ch.data_count;
        seen_req.data         = {req_ch.data_4, req_ch.data_3, req_ch.data_2,
                                 req_ch.data_1, req_ch.data_0};
        sb.frame_request(seen_req);
        beat_seen = 1'b1;
      end
      if (pkt_ch.valid && pkt_ch.ready) begin
        sb.check_byte(pkt_ch.out_byte, pkt_ch.last);
        beat_seen = 1'b1;
      end
      stall_run = beat_seen ? 0 : stall_run + 1;
    end
  end

  // Watchdog
  initial begin
    stall_run = 0;
    wait (stall_run >= STALL_LIMIT);
    $display("timeout after %0d cycles with no beat", STALL_LIMIT);
    $display("tb_dcc_packet_framer_core: errors");
    $finish;
  end

  // Byte sink: random stall pattern per phase, one long hold-off
  initial begin
    int unsigned phase_left;
    int unsigned hold_left;
    int unsigned tick;
    bit          held;
    sink_mode_t  mode;
    phase_left    = 0;
    hold_left     = 0;
    tick          = 0;
    held          = 1'b0;
    mode          = SINK_OPEN;
    pkt_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!held && requests_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pkt_ch.ready = 1'b0;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          mode       = sink_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        case (mode)
          SINK_OPEN:    pkt_ch.ready = 1'b1;
          SINK_LIGHT:   pkt_ch.ready = ($urandom_range(0, 9) >= 3);
          SINK_PATTERN: pkt_ch.ready = (tick[1:0] != 2'b11);
          default:      pkt_ch.ready = ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  function automatic dcc_request_t mk_request(logic [2:0] kind, logic long_address,
                                              logic [13:0] address, logic [2:0] count,
                                              logic [7:0] d0, logic [7:0] d1,
                                              logic [7:0] d2, logic [7:0] d3,
                                              logic [7:0] d4);
    dcc_request_t r;
    r.kind         = kind;
    r.long_address = long_address;
    r.address      = address;
    r.data_count   = count;
    r.data         = {d4, d3, d2, d1, d0};
    return r;
  endfunction

  function automatic dcc_request_t random_request();
    dcc_request_t r;
    int unsigned  roll;
    roll           = $urandom_range(0, 99);
    r.kind         = (roll < 8) ? 3'($urandom_range(KIND_UNSUPPORTED, KIND_TOP))
                                : 3'($urandom_range(dcc_pkg::KIND_IDLE, dcc_pkg::KIND_OTHER));
    r.long_address = 1'($urandom_range(0, 1));
    roll           = $urandom_range(0, 9);
    // mostly full-range addresses, some pinned to the extremes
    r.address      = (roll == 0) ? 14'h0000 : (roll == 1) ? 14'h3FFF
                                 : 14'($urandom_range(0, 16383));
    r.data_count   = 3'($urandom_range(0, 7));
    for (int k = 0; k < dcc_pkg::DATA_FIELDS; k++) r.data[k] = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Offer one request; bursts of back-to-back beats with random gaps between.
  // Called at a falling edge, returns at the falling edge after the beat.
  task automatic send_request(dcc_request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.kind         = r.kind;
    req_ch.long_address = r.long_address;
    req_ch.address      = r.address;
    req_ch.data_count   = r.data_count;
    req_ch.data_0       = r.data[0];
    req_ch.data_1       = r.data[1];
    req_ch.data_2       = r.data[2];
    req_ch.data_3       = r.data[3];
    req_ch.data_4       = r.data[4];
    req_ch.valid        = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    requests_sent++;
  endtask

  // Main sequence
  initial begin
    dcc_request_t directed[$];
    dcc_request_t r;
    int unsigned  framed_sent;
    requests_sent       = 0;
    burst_left          = 0;
    framed_sent         = 0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = dcc_pkg::KIND_IDLE;
    req_ch.long_address = 1'b0;
    req_ch.address      = '0;
    req_ch.data_count   = '0;
    req_ch.data_0       = '0;
    req_ch.data_1       = '0;
    req_ch.data_2       = '0;
    req_ch.data_3       = '0;
    req_ch.data_4       = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // idle packets; address form is ignored outside multifunction
    directed.push_back(mk_request(dcc_pkg::KIND_IDLE, 1'b0, 14'h0000, 3'd0, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_IDLE, 1'b1, 14'h3FFF, 3'd5, 8'hFF, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF));
    // multifunction, short and long address extremes
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b0, 14'h0000, 3'd0, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b0, 14'h3FFF, 3'd1, 8'hFF, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b0, 14'h007F, 3'd5, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b1, 14'h0000, 3'd0, 8'h00, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b1, 14'h3FFF, 3'd5, 8'hFF, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF));
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b1, 14'h2AAA, 3'd3, 8'h55, 8'hAA,
                                  8'h0F, 8'h00, 8'h00));
    // basic accessory: data_0 feeds the second address byte even with no data sent
    directed.push_back(mk_request(dcc_pkg::KIND_BASIC, 1'b0, 14'h0000, 3'd0, 8'hFF, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_BASIC, 1'b0, 14'h3FFF, 3'd1, 8'h07, 8'h00,
                                  8'h00, 8'h00, 8'h00));
    directed.push_back(mk_request(dcc_pkg::KIND_BASIC, 1'b0, 14'h1555, 3'd5, 8'hF8, 8'h12,
                                  8'h34, 8'h56, 8'h78));
    directed.push_back(mk_request(dcc_pkg::KIND_BASIC, 1'b1, 14'h0100, 3'd2, 8'hA5, 8'h5A,
                                  8'h00, 8'h00, 8'h00));
    // other accessory: empty packet is a lone zero check byte
    directed.push_back(mk_request(dcc_pkg::KIND_OTHER, 1'b0, 14'h3FFF, 3'd0, 8'hFF, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF));
    directed.push_back(mk_request(dcc_pkg::KIND_OTHER, 1'b1, 14'h0000, 3'd5, 8'hFF, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF));
    directed.push_back(mk_request(dcc_pkg::KIND_OTHER, 1'b0, 14'h1234, 3'd1, 8'h00, 8'hFF,
                                  8'hFF, 8'hFF, 8'hFF));
    // data count above the limit saturates
    directed.push_back(mk_request(dcc_pkg::KIND_MULTI, 1'b1, 14'h0C35, 3'd6, 8'h01, 8'h02,
                                  8'h04, 8'h08, 8'h10));
    directed.push_back(mk_request(dcc_pkg::KIND_BASIC, 1'b0, 14'h0ABC, 3'd7, 8'h20, 8'h40,
                                  8'h80, 8'hC3, 8'h3C));
    directed.push_back(mk_request(dcc_pkg::KIND_OTHER, 1'b0, 14'h0000, 3'd7, 8'h11, 8'h22,
                                  8'h33, 8'h44, 8'h55));
    directed.push_back(mk_request(dcc_pkg::KIND_IDLE, 1'b0, 14'h0000, 3'd7, 8'h99, 8'h88,
                                  8'h77, 8'h66, 8'h55));
    // unsupported kinds give no bytes
    for (int k = KIND_UNSUPPORTED; k <= KIND_TOP; k++)
      directed.push_back(mk_request(3'(k), 1'(k), 14'h2BCD, 3'd5, 8'hEE, 8'hDD, 8'hCC,
                                    8'hBB, 8'hAA));

    foreach (directed[i]) send_request(directed[i]);

    // random requests; unsupported ones do not count toward the packet total
    while (framed_sent < RANDOM_PACKETS) begin
      r = random_request();
      send_request(r);
      if (r.kind <= dcc_pkg::KIND_OTHER) framed_sent++;
    end
    req_ch.valid = 1'b0;

    // drain, then watch a little longer for stray beats
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d unsupported) and %0d checked bytes, %0d mismatches",
             sb.requests_seen, sb.silent_requests, sb.bytes_checked, sb.mismatches);
    $display("all kinds, both address forms, data counts 0-7, one %0d-cycle sink hold-off",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("tb_dcc_packet_framer_core: clean");
    end else begin
      $display("tb_dcc_packet_framer_core: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dcc_pkg.sv
rtl/dcc_req_if.sv
rtl/dcc_byte_if.sv
rtl/dcc_cell.sv
rtl/dcc_frame_load.sv
rtl/dcc_packet_framer_core.sv
tb/tb_dcc_packet_framer_core.sv
